// File: rtl/vda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Vector distance accumulator package
// Shared widths, metric codes and the fold result type.
// ----------------------------------------------------------------------------
package vda_pkg;

   // element and accumulator widths
   localparam int ELEM_WIDTH   = 8;
   localparam int ACC_WIDTH    = 32;
   localparam int DIST_WIDTH   = 32;
   localparam int METRIC_WIDTH = 2;

   // working width for sums and compares: holds any fold before clamping
   localparam int SQ_WIDTH   = 2 * ELEM_WIDTH;
   localparam int WIDE_WIDTH = ((ACC_WIDTH > SQ_WIDTH) ? ACC_WIDTH : SQ_WIDTH) + 1;

   // accumulator saturation value, all ones
   localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};

   // metric codes
   localparam logic [METRIC_WIDTH-1:0] METRIC_SQ_EUCLID   = 2'd0;
   localparam logic [METRIC_WIDTH-1:0] METRIC_MANHATTAN   = 2'd1;
   localparam logic [METRIC_WIDTH-1:0] METRIC_CHEBYSHEV   = 2'd2;
   localparam logic [METRIC_WIDTH-1:0] METRIC_FAST_EUCLID = 2'd3;

   // new accumulator state after one fold
   typedef struct packed {
      logic [ACC_WIDTH-1:0] acc;
      logic                 sat;
   } fold_result_type;

endpackage : vda_pkg
`default_nettype wire

// File: rtl/vda_fold.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Vector distance fold
// Folds the absolute difference of one element pair into the accumulator
// under the selected metric, with saturation.
// ----------------------------------------------------------------------------
module vda_fold (
   input  wire logic [vda_pkg::METRIC_WIDTH-1:0] metric,
   input  wire logic [vda_pkg::ACC_WIDTH-1:0]    acc_cur,
   input  wire logic                             sat_cur,
   input  wire logic signed [vda_pkg::ELEM_WIDTH-1:0] x_elem,
   input  wire logic signed [vda_pkg::ELEM_WIDTH-1:0] y_elem,
   output vda_pkg::fold_result_type              fold_out
);

   localparam int EW = vda_pkg::ELEM_WIDTH;
   localparam int WW = vda_pkg::WIDE_WIDTH;

   logic signed [EW:0]     diff;
   logic [EW-1:0]          abs_diff;
   logic [vda_pkg::SQ_WIDTH-1:0] sq;
   logic [WW-1:0]          acc_w;
   logic [WW-1:0]          ad_w;
   logic [WW-1:0]          max_w;
   logic [WW-1:0]          hi_w;
   logic [WW-1:0]          lo_w;
   logic [WW-1:0]          hi_clamp;
   logic                   hi_over;
   logic [WW-1:0]          addend;
   logic [WW-1:0]          base;
   logic [WW-1:0]          sum;
   logic                   sum_over;

   // full-width absolute difference, never wraps
   assign diff     = (EW+1)'(y_elem) - (EW+1)'(x_elem);
   assign abs_diff = diff[EW] ? EW'(-diff) : diff[EW-1:0];
   assign sq       = abs_diff * abs_diff;

   assign acc_w = WW'(acc_cur);
   assign ad_w  = WW'(abs_diff);
   assign max_w = WW'(vda_pkg::ACC_MAX);

   // larger and smaller of accumulator and difference
   assign hi_w     = (acc_w > ad_w) ? acc_w : ad_w;
   assign lo_w     = (acc_w > ad_w) ? ad_w : acc_w;
   assign hi_over  = hi_w > max_w;
   assign hi_clamp = hi_over ? max_w : hi_w;

   // operands of the saturating add per metric
   always_comb begin
      base   = acc_w;
      addend = '0;
      case (metric)
         vda_pkg::METRIC_SQ_EUCLID: begin
            addend = WW'(sq);
         end
         vda_pkg::METRIC_MANHATTAN: begin
            addend = ad_w;
         end
         vda_pkg::METRIC_FAST_EUCLID: begin
            base   = hi_clamp;
            addend = (lo_w >> 2) + (lo_w >> 3);
         end
         default: begin
            addend = '0;
         end
      endcase
   end

   assign sum      = base + addend;
   assign sum_over = sum > max_w;

   // select the new accumulator
   always_comb begin
      fold_out.acc = acc_cur;
      fold_out.sat = sat_cur;
      case (metric)
         vda_pkg::METRIC_CHEBYSHEV: begin
            if (ad_w > acc_w) begin
               fold_out.acc = hi_over ? vda_pkg::ACC_MAX
                                      : vda_pkg::ACC_WIDTH'(ad_w);
               fold_out.sat = sat_cur | hi_over;
            end
         end
         vda_pkg::METRIC_FAST_EUCLID: begin
            fold_out.acc = sum_over ? vda_pkg::ACC_MAX : vda_pkg::ACC_WIDTH'(sum);
            fold_out.sat = sat_cur | hi_over | sum_over;
         end
         default: begin
            fold_out.acc = sum_over ? vda_pkg::ACC_MAX : vda_pkg::ACC_WIDTH'(sum);
            fold_out.sat = sat_cur | sum_over;
         end
      endcase
   end

endmodule : vda_fold
`default_nettype wire

// File: rtl/vector_distance_accumulator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Vector distance accumulator
// Streams element pairs, folds them into a running distance and emits one
// result beat per vector.
// ----------------------------------------------------------------------------
// The block takes one element pair beat per clock, unless req_stall holds a last
// pair, and returns one result beat on each pair flagged last. A pair goes into
// an input register and is folded into the accumulator from there; when last,
// the fold lands in the result register at that same edge instead, and the
// accumulator clears. The fold of the accumulator with one pair is a loop through
// the accumulator register, which sets the sustained rate of one pair per cycle
// while no last pair waits. Non-last pairs keep folding while a result beat waits
// downstream; only a last pair waits for the result register to free.
// metric_select is written through the csr port, which is always ready.
// ----------------------------------------------------------------------------
module vector_distance_accumulator_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // element pair channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [vda_pkg::ELEM_WIDTH-1:0] req_x_elem,
   input  wire logic signed [vda_pkg::ELEM_WIDTH-1:0] req_y_elem,
   input  wire logic                                 req_last_elem,
   // result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [vda_pkg::DIST_WIDTH-1:0]            rsp_distance,
   output logic                                      rsp_overflow,
   // configuration
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [vda_pkg::METRIC_WIDTH-1:0]     csr_metric_select
);

   // input register
   logic                                  in_valid_ff, in_valid_in;
   logic signed [vda_pkg::ELEM_WIDTH-1:0] in_x_ff;
   logic signed [vda_pkg::ELEM_WIDTH-1:0] in_y_ff;
   logic                                  in_last_ff;

   // accumulator and config
   logic [vda_pkg::ACC_WIDTH-1:0]    acc_ff, acc_in;
   logic                             sat_ff, sat_in;
   logic [vda_pkg::METRIC_WIDTH-1:0] metric_ff, metric_in;

   // result register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [vda_pkg::DIST_WIDTH-1:0]   rsp_distance_ff;
   logic                             rsp_overflow_ff;

   vda_pkg::fold_result_type fold_res;

   logic out_free;
   logic fold_go;
   logic req_take;

   // handshake control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fold_go   = in_valid_ff && (!in_last_ff || out_free);
   assign req_stall = in_valid_ff && !fold_go;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // fold datapath
   vda_fold u_fold (
      .metric   (metric_ff),
      .acc_cur  (acc_ff),
      .sat_cur  (sat_ff),
      .x_elem   (in_x_ff),
      .y_elem   (in_y_ff),
      .fold_out (fold_res)
   );

   // next-state logic
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fold_go) begin
         in_valid_in = 1'b0;
      end

      acc_in = acc_ff;
      sat_in = sat_ff;
      if (fold_go) begin
         if (in_last_ff) begin
            acc_in = '0;
            sat_in = 1'b0;
         end else begin
            acc_in = fold_res.acc;
            sat_in = fold_res.sat;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (fold_go && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      metric_in = metric_ff;
      if (csr_valid && csr_ready) begin
         metric_in = csr_metric_select;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         metric_ff    <= vda_pkg::METRIC_SQ_EUCLID;
      end else begin
         in_valid_ff  <= in_valid_in;
         acc_ff       <= acc_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
         metric_ff    <= metric_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_x_ff    <= req_x_elem;
         in_y_ff    <= req_y_elem;
         in_last_ff <= req_last_elem;
      end
      if (fold_go && in_last_ff) begin
         rsp_distance_ff <= vda_pkg::DIST_WIDTH'(fold_res.acc);
         rsp_overflow_ff <= fold_res.sat;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule : vector_distance_accumulator_top
`default_nettype wire
